[design/fmdt_pkg.sv]
`timescale 1ns / 1ps
// Package with the shared constants, codes and types of the deduplicating queue.
package fmdt_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CNT_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 104;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic                   push;
        logic                   pop;
        logic [VALUE_WIDTH-1:0] value;
    } t_cell_ctrl;

endpackage

[design/fmdt_cell.sv]
`timescale 1ns / 1ps
// One queue slot: holds an entry, compares it and shifts toward the head.
module fmdt_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fmdt_pkg::t_cell_ctrl           i_ctrl,
    input  logic                           i_prev_valid,
    input  logic                           i_next_valid,
    input  logic [fmdt_pkg::VALUE_WIDTH-1:0] i_next_data,
    input  logic                           i_hit,
    output logic                           o_valid,
    output logic [fmdt_pkg::VALUE_WIDTH-1:0] o_data,
    output logic                           o_match,
    output logic                           o_hit
);

    logic                             r_valid;
    logic [fmdt_pkg::VALUE_WIDTH-1:0] r_data;
    logic                             n_valid;
    logic [fmdt_pkg::VALUE_WIDTH-1:0] n_data;
    logic                             w_match;

    assign w_match = r_valid && (r_data == i_ctrl.value);

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.pop) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_ctrl.push) begin
            if (r_valid && (i_hit || w_match)) begin
                // Entries behind the duplicate move up; the last one takes the value.
                n_data = i_next_valid ? i_next_data : i_ctrl.value;
            end else if (!r_valid && i_prev_valid && !i_hit) begin
                n_valid = 1'b1;
                n_data  = i_ctrl.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_match = w_match;
    assign o_hit   = i_hit || w_match;

endmodule

[design/fifo_move_duplicate_to_tail_core.sv]
`timescale 1ns / 1ps
// A result is first held in the pending register and then moved into the output register.
// Throughput: one item per cycle while the output side takes results.
// Every slot compares the pushed value in parallel and shifts at most one place per item.
// Reset empties the queue; entry data is left as it is and never read while invalid.
// The output register holds a result while a new item is accepted.
module fifo_move_duplicate_to_tail_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [fmdt_pkg::VALUE_WIDTH-1:0]      s_axis_tdata,  // [31:0] value
    input  logic                                  s_axis_tuser,  // [0] op
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [31:0] popped_value, [63:32] front_value, [95:64] back_value,
    // [100:96] entry_count, [101] is_empty, [103:102] zero
    output logic [fmdt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [fmdt_pkg::STATUS_W-1:0]         m_axis_tuser   // [1:0] status
);

    localparam int DEPTH = fmdt_pkg::DEPTH;
    localparam int VW    = fmdt_pkg::VALUE_WIDTH;
    localparam int OW    = fmdt_pkg::OUT_WIDTH;
    localparam int CW    = fmdt_pkg::CNT_W;

    logic                     w_in_acc;
    logic                     w_slot_free;
    logic                     w_load;
    fmdt_pkg::t_cell_ctrl     w_ctrl;
    logic [DEPTH-1:0]         w_valid;
    logic [DEPTH-1:0]         w_match;
    logic [DEPTH:0]           w_hit;
    logic [VW-1:0]            w_data [DEPTH];
    logic [VW-1:0]            w_back;
    logic                     w_any_hit;

    logic                     r_pend;
    fmdt_pkg::t_status        r_pend_status;
    logic [VW-1:0]            r_pend_popped;
    fmdt_pkg::t_status        n_status;
    logic [VW-1:0]            n_popped;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;

    logic                     r_ovalid;
    fmdt_pkg::t_status        r_o_status;
    logic [OW-1:0]            r_o_popped;
    logic [OW-1:0]            r_o_front;
    logic [OW-1:0]            r_o_back;
    logic [CW-1:0]            r_o_count;
    logic                     r_o_empty;

    assign w_slot_free   = !r_ovalid || m_axis_tready;
    assign w_load        = r_pend && w_slot_free;
    assign s_axis_tready = !r_pend || w_slot_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_ctrl.push  = w_in_acc && (s_axis_tuser == fmdt_pkg::OP_PUSH);
    assign w_ctrl.pop   = w_in_acc && (s_axis_tuser == fmdt_pkg::OP_POP);
    assign w_ctrl.value = s_axis_tdata;

    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic          w_prev_valid;
        logic          w_next_valid;
        logic [VW-1:0] w_next_data;
        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_data  = '0;
        end else begin : g_mid
            assign w_next_valid = w_valid[g+1];
            assign w_next_data  = w_data[g+1];
        end
        fmdt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_data  (w_next_data),
            .i_hit        (w_hit[g]),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g]),
            .o_match      (w_match[g]),
            .o_hit        (w_hit[g+1])
        );
    end

    assign w_any_hit = w_hit[DEPTH];

    always_comb begin
        w_back = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_valid[k] && ((k == DEPTH - 1) || !w_valid[(k + 1) % DEPTH])) begin
                w_back = w_back | w_data[k];
            end
        end
    end

    always_comb begin
        n_status = fmdt_pkg::ST_OK;
        n_popped = '0;
        n_count  = r_count;
        if (s_axis_tuser == fmdt_pkg::OP_POP) begin
            if (r_count == '0) begin
                n_status = fmdt_pkg::ST_EMPTY;
            end else begin
                n_popped = w_data[0];
                n_count  = r_count - CW'(1);
            end
        end else begin
            if (w_any_hit) begin
                n_status = fmdt_pkg::ST_DUP;
            end else if (r_count == CW'(DEPTH)) begin
                n_status = fmdt_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_pend  <= 1'b1;
                r_count <= n_count;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pend_status <= n_status;
            r_pend_popped <= n_popped;
        end
        if (w_load) begin
            r_o_status <= r_pend_status;
            r_o_popped <= OW'(r_pend_popped);
            r_o_front  <= w_valid[0] ? OW'(w_data[0]) : '0;
            r_o_back   <= OW'(w_back);
            r_o_count  <= r_count;
            r_o_empty  <= (r_count == '0);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {2'b00, r_o_empty, r_o_count, r_o_back, r_o_front, r_o_popped};

`ifndef ASSERT_OFF
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("entry count differs from the number of valid slots");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + DEPTH'(1))) == '0)
        else $error("valid slots are not packed toward the head");

    a_unique_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("a value is held in more than one slot");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> (r_count == $past(r_count)))
        else $error("entry count changed without an accepted item");
`endif

endmodule

[sim/fmdt_queue_checker.sv]
`timescale 1ns / 1ps
// Checker that mirrors the deduplicating queue and compares every result the block returns.
module fmdt_queue_checker
    import fmdt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [VALUE_WIDTH-1:0] i_in_value,   // [31:0] value
    input  logic                   i_in_op,      // [0] op
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    // [31:0] popped_value, [63:32] front_value, [95:64] back_value,
    // [100:96] entry_count, [101] is_empty, [103:102] zero
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    input  logic [STATUS_W-1:0]    i_out_status, // [1:0] status
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        t_status              status;
        logic [1:0]           pad;
        logic                 empty;
        logic [CNT_W-1:0]     count;
        logic [OUT_WIDTH-1:0] back;
        logic [OUT_WIDTH-1:0] front;
        logic [OUT_WIDTH-1:0] popped;
    } t_queue_result;

    logic [VALUE_WIDTH-1:0] queue_mirror[$];
    t_queue_result          expected_results[$];
    int                     fail_total = 0;
    int                     pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic t_queue_result apply_item(input logic op,
                                                 input logic [VALUE_WIDTH-1:0] value);
        t_queue_result r;
        int            at;
        r  = '0;
        at = -1;
        if (op == OP_POP) begin
            if (queue_mirror.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped = queue_mirror.pop_front();
                r.status = ST_OK;
            end
        end else begin
            foreach (queue_mirror[k]) begin
                if (at < 0 && queue_mirror[k] == value) begin
                    at = k;
                end
            end
            if (at >= 0) begin
                r.status = ST_DUP;
                if (at != queue_mirror.size() - 1) begin
                    queue_mirror.delete(at);
                    queue_mirror.push_back(value);
                end
            end else if (queue_mirror.size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                queue_mirror.push_back(value);
                r.status = ST_OK;
            end
        end
        if (queue_mirror.size() != 0) begin
            r.front = queue_mirror[0];
            r.back  = queue_mirror[queue_mirror.size() - 1];
        end
        r.count = CNT_W'(queue_mirror.size());
        r.empty = (queue_mirror.size() == 0);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [OUT_WIDTH-1:0] want,
                               input logic [OUT_WIDTH-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_queue_result want;
        t_queue_result got;
        if (!i_rst_n) begin
            queue_mirror.delete();
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_item(i_in_op, i_in_value));
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_out_status, i_out_data};
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", OUT_WIDTH'(want.status), OUT_WIDTH'(got.status));
                    check_field("popped_value", want.popped, got.popped);
                    check_field("front_value", want.front, got.front);
                    check_field("back_value", want.back, got.back);
                    check_field("entry_count", OUT_WIDTH'(want.count), OUT_WIDTH'(got.count));
                    check_field("is_empty", OUT_WIDTH'(want.empty), OUT_WIDTH'(got.empty));
                    check_field("padding", OUT_WIDTH'(want.pad), OUT_WIDTH'(got.pad));
                end
            end
        end
        pending_total <= expected_results.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench top that drives push and pop items into the deduplicating queue and reports the verdict.
module tb;
    import fmdt_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [VALUE_WIDTH-1:0] s_axis_tdata = '0;   // [31:0] value
    logic                   s_axis_tuser = OP_PUSH; // [0] op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] popped_value, [63:32] front_value, [95:64] back_value,
    // [100:96] entry_count, [101] is_empty, [103:102] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;        // [1:0] status

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic long_hold_request = 1'b0;
    logic long_hold_done = 1'b0;
    int   hold_left = 0;
    int   fail_count;
    int   pending_results;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    fifo_move_duplicate_to_tail_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fmdt_queue_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_value   (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_status (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // The receiver can be held off for a long stretch so that the block backs up.
    always @(posedge i_clk) begin
        if (long_hold_request && !long_hold_done) begin
            hold_left      = 80;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic op, input logic [VALUE_WIDTH-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Items come in bursts that share a small pool of values, so duplicates and a full queue
    // are frequent; the push share of each burst decides whether the queue fills or drains.
    task automatic run_random_items(input int count);
        logic [VALUE_WIDTH-1:0] pool_base;
        logic [VALUE_WIDTH-1:0] value;
        int                     pool_size;
        int                     push_pct;
        logic                   op;
        pool_base = '0;
        pool_size = 1;
        push_pct  = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) begin
                pool_base = $urandom;
                pool_size = $urandom_range(24, 3);
                case ($urandom_range(2))
                    0: push_pct = 35;
                    1: push_pct = 55;
                    default: push_pct = 80;
                endcase
            end
            op    = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            value = ($urandom_range(9) == 0) ? $urandom : pool_base + $urandom_range(pool_size - 1);
            send_item(op, value);
        end
    endtask

    initial begin
        tx_idle_pct = 11;
        rx_idle_pct <= 72;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_POP, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_POP, 32'h0000_0000);
        send_item(OP_POP, 32'hA5A5_A5A5);
        send_item(OP_POP, 32'h5A5A_5A5A);
        for (int k = 0; k < DEPTH; k++) begin
            send_item(OP_PUSH, 32'h5A5A_0000 + k);
        end
        send_item(OP_PUSH, 32'h1234_5678);
        send_item(OP_PUSH, 32'h5A5A_0007);

        run_random_items(127);
        tx_idle_pct = 72;
        rx_idle_pct <= 11;
        run_random_items(127);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        long_hold_request <= 1'b1;
        run_random_items(127);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
